FILE: design/connection_heartbeat_monitor_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the connection heartbeat monitor
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef CONNECTION_HEARTBEAT_MONITOR_ASSERT_SVH
`define CONNECTION_HEARTBEAT_MONITOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CHM_ASSERT_NOW(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define CHM_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("assertion failed");

`endif

FILE: design/chm_pkg.sv
// ----------------------------------------------------------------------------
// Heartbeat monitor package
// Sizes, operation codes, register indexes and controller types.
// ----------------------------------------------------------------------------
package chm_pkg;

	localparam int SLOT_COUNT = 64;
	localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	localparam int OP_W      = 3;
	localparam int SLOT_ID_W = 6;
	localparam int TIMEOUT_W = 16;
	localparam int TICK_W    = 17;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 16;

	typedef logic [SLOT_COUNT-1:0] slot_vec_t;
	typedef logic [SLOT_W-1:0]     slot_idx_t;

	typedef enum logic [OP_W-1:0] {
		OP_TICK   = 3'd0,
		OP_ADD    = 3'd1,
		OP_DELETE = 3'd2,
		OP_HEARD  = 3'd3,
		OP_CLEAR  = 3'd4
	} op_t;

	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 1'd1;

	typedef enum logic {
		ST_IDLE,
		ST_SWEEP
	} state_t;

	typedef struct packed {
		logic accept;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic sweep_req;
		logic out_busy;
		logic last_idx;
	} status_t;

endpackage

FILE: design/chm_ifs.sv
// ----------------------------------------------------------------------------
// Heartbeat monitor channels
// Valid/ready request channels for operations and dropped-slot reports.
// ----------------------------------------------------------------------------
interface chm_in_if
	import chm_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [OP_W-1:0]      op;
	logic [SLOT_ID_W-1:0] slot_id;

	modport source (output valid, output op, output slot_id, input ready);
	modport sink   (input valid, input op, input slot_id, output ready);
endinterface

interface chm_out_if
	import chm_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [SLOT_ID_W-1:0] dropped_slot;
	logic                 last_of_sweep;

	modport source (output valid, output dropped_slot, output last_of_sweep, input ready);
	modport sink   (input valid, input dropped_slot, input last_of_sweep, output ready);
endinterface

FILE: design/chm_ctrl.sv
// ----------------------------------------------------------------------------
// Heartbeat monitor controller
// Accepts requests while idle and paces the slot-by-slot sweep.
// ----------------------------------------------------------------------------
module chm_ctrl
	import chm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd.accept = 1'b0;
		cmd.step   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && status.sweep_req) begin
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				// The output register must be free before a slot is examined.
				cmd.step = !status.out_busy;
				if (!status.out_busy && status.last_idx) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: design/chm_datapath.sv
// ----------------------------------------------------------------------------
// Heartbeat monitor datapath
// Slot bit tables, tick counter, configuration and the result register.
// ----------------------------------------------------------------------------
module chm_datapath
	import chm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_wdata,
	input  logic [OP_W-1:0]      op,
	input  logic [SLOT_ID_W-1:0] slot_id,
	input  cmd_t                 cmd,
	output status_t              status,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [SLOT_ID_W-1:0] dropped_slot,
	output logic                 last_of_sweep
);

	logic [TIMEOUT_W-1:0] timeout_q;
	logic                 enable_q;
	logic [TICK_W-1:0]    tick_q;
	slot_vec_t            member_q;
	slot_vec_t            waiting_q;
	slot_idx_t            idx_q;
	logic                 out_valid_q;
	logic [SLOT_ID_W-1:0] dropped_q;
	logic                 last_q;

	logic [TICK_W-1:0]    tick_nx;
	logic                 tick_over;
	logic                 slot_ok;
	logic                 edit_ok;
	slot_idx_t            sidx;
	slot_vec_t            sel;
	slot_vec_t            upper;
	logic                 hit;
	logic                 later_wait;
	logic                 kept;

	always_comb begin
		tick_nx    = tick_q + TICK_W'(1);
		tick_over  = tick_nx > TICK_W'(timeout_q);
		slot_ok    = (7'(slot_id) < 7'(SLOT_COUNT));
		edit_ok    = enable_q && slot_ok;
		sidx       = slot_id[SLOT_W-1:0];
		sel        = slot_vec_t'(1) << idx_q;
		upper      = ~(sel | (sel - slot_vec_t'(1)));
		hit        = waiting_q[idx_q];
		later_wait = |(waiting_q & upper);
		kept       = member_q[idx_q] & ~waiting_q[idx_q];
	end

	assign status.sweep_req = (op == OP_TICK) && tick_over;
	assign status.out_busy  = out_valid_q && !out_ready;
	assign status.last_idx  = (idx_q == SLOT_W'(SLOT_COUNT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_W'(30);
			enable_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TIMEOUT: timeout_q <= cfg_wdata[TIMEOUT_W-1:0];
				CFG_ENABLE:  enable_q  <= cfg_wdata[0];
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q    <= '0;
			member_q  <= '0;
			waiting_q <= '0;
			idx_q     <= '0;
		end else if (cmd.accept) begin
			case (op)
				OP_TICK: begin
					tick_q <= tick_over ? '0 : tick_nx;
					idx_q  <= '0;
				end
				OP_ADD: begin
					if (edit_ok) member_q[sidx] <= 1'b1;
				end
				OP_DELETE: begin
					if (edit_ok) begin
						member_q[sidx]  <= 1'b0;
						waiting_q[sidx] <= 1'b0;
					end
				end
				OP_HEARD: begin
					if (edit_ok) waiting_q[sidx] <= 1'b0;
				end
				OP_CLEAR: begin
					member_q  <= '0;
					waiting_q <= '0;
				end
				default: ;
			endcase
		end else if (cmd.step) begin
			// A waiting slot drops out; a surviving member starts waiting.
			member_q[idx_q]  <= kept;
			waiting_q[idx_q] <= kept;
			idx_q            <= idx_q + SLOT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step && hit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && hit) begin
			dropped_q <= SLOT_ID_W'(idx_q);
			last_q    <= !later_wait;
		end
	end

	assign out_valid     = out_valid_q;
	assign dropped_slot  = dropped_q;
	assign last_of_sweep = last_q;

endmodule

FILE: design/connection_heartbeat_monitor.sv
// ----------------------------------------------------------------------------
// Connection heartbeat monitor
// Server-side heartbeat timeout watchdog over a table of connection slots.
// ----------------------------------------------------------------------------
// Each request carries an operation (tick, add, delete, heard, clear all) and
// a slot number. Add, delete, heard and clear complete when accepted and the
// block is ready for the next request in the following cycle. A tick that
// pushes the tick count past timeout_ticks starts a sweep: a sequencer walks
// the slots one per clock, pausing while a dropped-slot report waits in the
// output register for the downstream side. Requests are held off while the
// sweep runs. Dropped slots come out in ascending order, the final one of a
// sweep marked by last_of_sweep; a sweep that finds nothing reports nothing.
// Add, delete and heard only take effect while monitor_enable is set. The
// user is to write configuration through the plain write port only while no
// request is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module connection_heartbeat_monitor
	import chm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	chm_in_if.sink               in_ch,
	chm_out_if.source            out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_wdata
);

	// Commands from the controller and status from the datapath.
	cmd_t    cmd;
	status_t status;

	// The controller owns the handshake and the sweep pacing.
	chm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds the slot tables, the tick counter, the registers and
	// the result register that decouples the sweep from the consumer.
	chm_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.op            (in_ch.op),
		.slot_id       (in_ch.slot_id),
		.cmd           (cmd),
		.status        (status),
		.out_valid     (out_ch.valid),
		.out_ready     (out_ch.ready),
		.dropped_slot  (out_ch.dropped_slot),
		.last_of_sweep (out_ch.last_of_sweep)
	);

endmodule

FILE: design/chm_checker.sv
// ----------------------------------------------------------------------------
// Heartbeat monitor checker
// Port-level assertions on the request and report channels.
// ----------------------------------------------------------------------------
`include "connection_heartbeat_monitor_assert.svh"

module chm_checker
	import chm_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [SLOT_ID_W-1:0] dropped_slot,
	input logic                 last_of_sweep
);

	// A stalled report keeps its contents.
	`CHM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(dropped_slot) && $stable(last_of_sweep))

	// A report that is not the last of its sweep means the sweep is still running.
	`CHM_ASSERT_NOW(a_sweep_busy, clk, arst_n, out_valid && !last_of_sweep, !in_ready)

	// The block only stops taking requests after it has taken one.
	`CHM_ASSERT_NOW(a_busy_cause, clk, arst_n, $fell(in_ready), $past(in_valid))

endmodule

bind connection_heartbeat_monitor chm_checker u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.dropped_slot  (out_ch.dropped_slot),
	.last_of_sweep (out_ch.last_of_sweep)
);
